// ----- rtl/dpb_pkg.sv -----
// Shared types, widths and constants of the depth pixel back-projection unit.
package dpb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_W        = 16;
  localparam int CENTER_W       = 16;
  localparam int RECIP_W        = 24;
  localparam int POINT_W        = 24;
  localparam int STEP_W         = 4;
  localparam int ZFULL_W        = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int OUT_TDATA_W    = 72;
  localparam int NUM_STAGES     = 5;

  localparam logic [POINT_W-1:0] SAT_POS = 24'h7FFFFF;
  localparam logic [POINT_W-1:0] SAT_NEG = 24'h800000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER_COL      = 3'd0,
    CFG_CENTER_ROW      = 3'd1,
    CFG_INV_FOCAL_COL   = 3'd2,
    CFG_INV_FOCAL_ROW   = 3'd3,
    CFG_METRES_PER_UNIT = 3'd4,
    CFG_MIN_DEPTH       = 3'd5,
    CFG_MAX_DEPTH       = 3'd6,
    CFG_SKIP_STEP       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CENTER_W-1:0] center_col;
    logic [CENTER_W-1:0] center_row;
    logic [RECIP_W-1:0]  inv_focal_col;
    logic [RECIP_W-1:0]  inv_focal_row;
    logic [RECIP_W-1:0]  metres_per_unit;
    logic [POINT_W-1:0]  min_depth;
    logic [POINT_W-1:0]  max_depth;
    logic [STEP_W-1:0]   skip_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_col:      16'd10462,
    center_row:      16'd5850,
    inv_focal_col:   24'd26011,
    inv_focal_row:   24'd26040,
    metres_per_unit: 24'd16777,
    min_depth:       24'd32768,
    max_depth:       24'd327680,
    skip_step:       4'd2
  };

endpackage

// ----- rtl/dpb_cfg_regs.sv -----
// Configuration register file of the depth pixel back-projection unit.
module dpb_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpb_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output dpb_pkg::cfg_t                    cfg_o
);

  dpb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dpb_pkg::cfg_reg_e'(cfg_addr_i))
        dpb_pkg::CFG_CENTER_COL:      cfg_d.center_col      = cfg_wdata_i[15:0];
        dpb_pkg::CFG_CENTER_ROW:      cfg_d.center_row      = cfg_wdata_i[15:0];
        dpb_pkg::CFG_INV_FOCAL_COL:   cfg_d.inv_focal_col   = cfg_wdata_i;
        dpb_pkg::CFG_INV_FOCAL_ROW:   cfg_d.inv_focal_row   = cfg_wdata_i;
        dpb_pkg::CFG_METRES_PER_UNIT: cfg_d.metres_per_unit = cfg_wdata_i;
        dpb_pkg::CFG_MIN_DEPTH:       cfg_d.min_depth       = cfg_wdata_i;
        dpb_pkg::CFG_MAX_DEPTH:       cfg_d.max_depth       = cfg_wdata_i;
        dpb_pkg::CFG_SKIP_STEP:       cfg_d.skip_step       = cfg_wdata_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpb_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dpb_axis.sv -----
// One back-projection lane: offset, two multiply stages, rounding and saturation.
module dpb_axis #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic [dpb_pkg::NUM_STAGES-1:0]  en_i,
  input  logic [COORD_BITS-1:0]           coord_i,
  input  logic [dpb_pkg::CENTER_W-1:0]    center_i,
  input  logic [dpb_pkg::RECIP_W-1:0]     inv_f_i,
  input  logic [dpb_pkg::POINT_W-1:0]     z_i,
  output logic [dpb_pkg::POINT_W-1:0]     point_o
);

  localparam int SW   = COORD_BITS + 4;
  localparam int DW   = (SW > dpb_pkg::CENTER_W) ? SW : dpb_pkg::CENTER_W;
  localparam int PW   = DW + dpb_pkg::POINT_W;
  localparam int MW   = PW + 12;
  localparam int SUMW = MW + 1;
  localparam int MAGW = SUMW - 16;
  localparam logic [SUMW-1:0] ROUND_HALF = SUMW'(32'h8000);

  logic [DW-1:0]   scaled, center_ext, mag_d;
  logic            neg;
  logic [DW-1:0]   mag_d_q;
  logic            neg_a_q, neg_b_q, neg_c_q, neg_d_q;
  logic [PW-1:0]   prod_q;
  logic [MW-1:0]   hi_q, lo_q;
  logic [SUMW-1:0] sum_d;
  logic [MAGW-1:0] mag_q;
  logic [dpb_pkg::POINT_W-1:0] sat_mag, point_d, point_q;

  assign scaled     = DW'({coord_i, 4'b0000});
  assign center_ext = DW'(center_i);
  assign neg        = scaled < center_ext;
  assign mag_d      = neg ? (center_ext - scaled) : (scaled - center_ext);

  assign sum_d = SUMW'(hi_q) + SUMW'(lo_q[MW-1:12]) + ROUND_HALF;

  always_comb begin
    if (neg_d_q) begin
      sat_mag = (mag_q > MAGW'(dpb_pkg::SAT_NEG)) ? dpb_pkg::SAT_NEG
                                                  : mag_q[dpb_pkg::POINT_W-1:0];
      point_d = dpb_pkg::POINT_W'(0) - sat_mag;
    end else begin
      sat_mag = (mag_q > MAGW'(dpb_pkg::SAT_POS)) ? dpb_pkg::SAT_POS
                                                  : mag_q[dpb_pkg::POINT_W-1:0];
      point_d = sat_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_d_q <= mag_d;
      neg_a_q <= neg;
    end
    if (en_i[1]) begin
      prod_q  <= PW'(mag_d_q) * PW'(z_i);
      neg_b_q <= neg_a_q;
    end
    if (en_i[2]) begin
      hi_q    <= MW'(prod_q) * MW'(inv_f_i[23:12]);
      lo_q    <= MW'(prod_q) * MW'(inv_f_i[11:0]);
      neg_c_q <= neg_b_q;
    end
    if (en_i[3]) begin
      mag_q   <= sum_d[SUMW-1:16];
      neg_d_q <= neg_c_q;
    end
    if (en_i[4]) begin
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule

// ----- rtl/depth_pixel_backprojection_unit.sv -----
// Depth pixel back-projection unit: pixel stream in, 3-D point stream out.
// Throughput: one pixel per cycle while m_axis is ready; five register stages, each with its own valid bit.
// A stage advances when it is empty or the stage after it advances; dropped pixels leave bubbles.
// Reset clears all valid bits and loads the default camera configuration.
module depth_pixel_backprojection_unit #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
  localparam int IN_W      = ((2 * COORD_BITS + dpb_pkg::DEPTH_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpb_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,  // pixel_col, pixel_row, depth_raw
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dpb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // point_x, point_y, point_z
);

  localparam int CW    = COORD_BITS;
  localparam int CHUNK = (CW + 2) / 3;
  localparam int CPAD  = 3 * CHUNK;

  dpb_pkg::cfg_t cfg;

  logic [CW-1:0]   pixel_col, pixel_row;
  logic [dpb_pkg::DEPTH_W-1:0] depth_raw;
  logic [CPAD-1:0] col_pad, row_pad;
  logic [3:0]      step;
  logic [40:0]     zprod;
  logic            in_accept, z_in_range;
  logic [dpb_pkg::NUM_STAGES-1:0] en;

  logic            valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q;
  logic            valid_a_d, valid_b_d, valid_c_d;
  logic [CPAD-1:0] col_a_q, row_a_q, col_b_q, row_b_q;
  logic [3:0]      rcol_a_q, rrow_a_q, rcol_b_q, rrow_b_q, rcol_c, rrow_c;
  logic [dpb_pkg::ZFULL_W-1:0] z_a_q;
  logic [dpb_pkg::POINT_W-1:0] z_b_q, z_c_q, z_d_q, z_e_q;
  logic [dpb_pkg::POINT_W-1:0] point_x, point_y;

  function automatic logic [3:0] rem_chunk(input logic [3:0] r_in,
                                           input logic [CHUNK-1:0] bits,
                                           input logic [3:0] div);
    logic [4:0] t;
    logic [3:0] r;
    r = r_in;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, div}) t = t - {1'b0, div};
      r = t[3:0];
    end
    return r;
  endfunction

  dpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign pixel_col = s_axis_tdata[CW-1:0];
  assign pixel_row = s_axis_tdata[2*CW-1:CW];
  assign depth_raw = s_axis_tdata[2*CW+dpb_pkg::DEPTH_W-1:2*CW];
  assign col_pad   = CPAD'(pixel_col);
  assign row_pad   = CPAD'(pixel_row);
  assign step      = (cfg.skip_step == 4'd0) ? 4'd1 : cfg.skip_step;

  // advance a stage when it is empty or the next one advances
  assign en[4] = !valid_e_q || m_axis_tready;
  assign en[3] = !valid_d_q || en[4];
  assign en[2] = !valid_c_q || en[3];
  assign en[1] = !valid_b_q || en[2];
  assign en[0] = !valid_a_q || en[1];

  assign s_axis_tready = en[0];
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign zprod      = 41'(depth_raw) * 41'(cfg.metres_per_unit) + 41'd128;
  assign z_in_range = (z_a_q >= dpb_pkg::ZFULL_W'(cfg.min_depth)) &&
                      (z_a_q <= dpb_pkg::ZFULL_W'(cfg.max_depth));
  assign rcol_c     = rem_chunk(rcol_b_q, col_b_q[CHUNK-1:0], step);
  assign rrow_c     = rem_chunk(rrow_b_q, row_b_q[CHUNK-1:0], step);

  assign valid_a_d = in_accept && (depth_raw != '0);
  assign valid_b_d = valid_a_q && z_in_range;
  assign valid_c_d = valid_b_q && (rcol_c == 4'd0) && (rrow_c == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else begin
      if (en[0]) valid_a_q <= valid_a_d;
      if (en[1]) valid_b_q <= valid_b_d;
      if (en[2]) valid_c_q <= valid_c_d;
      if (en[3]) valid_d_q <= valid_c_q;
      if (en[4]) valid_e_q <= valid_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      col_a_q  <= col_pad;
      row_a_q  <= row_pad;
      rcol_a_q <= rem_chunk(4'd0, col_pad[CPAD-1 -: CHUNK], step);
      rrow_a_q <= rem_chunk(4'd0, row_pad[CPAD-1 -: CHUNK], step);
      z_a_q    <= zprod[39:8];
    end
    if (en[1]) begin
      col_b_q  <= col_a_q;
      row_b_q  <= row_a_q;
      rcol_b_q <= rem_chunk(rcol_a_q, col_a_q[2*CHUNK-1 -: CHUNK], step);
      rrow_b_q <= rem_chunk(rrow_a_q, row_a_q[2*CHUNK-1 -: CHUNK], step);
      z_b_q    <= z_a_q[dpb_pkg::POINT_W-1:0];
    end
    if (en[2]) z_c_q <= z_b_q;
    if (en[3]) z_d_q <= z_c_q;
    if (en[4]) z_e_q <= z_d_q;
  end

  dpb_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (pixel_col),
    .center_i (cfg.center_col),
    .inv_f_i  (cfg.inv_focal_col),
    .z_i      (z_a_q[dpb_pkg::POINT_W-1:0]),
    .point_o  (point_x)
  );

  dpb_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .coord_i  (pixel_row),
    .center_i (cfg.center_row),
    .inv_f_i  (cfg.inv_focal_row),
    .z_i      (z_a_q[dpb_pkg::POINT_W-1:0]),
    .point_o  (point_y)
  );

  assign m_axis_tvalid = valid_e_q;
  assign m_axis_tdata  = {z_e_q, point_y, point_x};

  a_zero_depth_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (depth_raw == '0)) |=> !valid_a_q)
    else $error("zero depth pixel entered the pipeline");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_a_q |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_d_q && !en[4]) |=> valid_d_q && valid_e_q)
    else $error("stalled stage lost its request");

  a_out_follows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_d_q && en[4]) |=> m_axis_tvalid)
    else $error("advanced request did not reach the output");

endmodule

// ----- verif/tb_depth_pixel_backprojection_unit.sv -----
// Self-checking testbench: pixel stream against a fixed-point back-projection predictor.
module tb_depth_pixel_backprojection_unit;
  import dpb_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_PTS   = 95;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_DIR     = 36;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_raw;
    logic [CB-1:0]      pixel_row;
    logic [CB-1:0]      pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [POINT_W-1:0] z;
    logic [POINT_W-1:0] y;
    logic [POINT_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_DROP, CHK_GIVEN} check_e;

  typedef struct packed {
    logic               is_cfg;
    cfg_reg_e           cfg_sel;
    logic [23:0]        cfg_val;
    logic [CB-1:0]      col;
    logic [CB-1:0]      row;
    logic [DEPTH_W-1:0] raw;
    check_e             chk;
    logic [POINT_W-1:0] given_x;
    logic [POINT_W-1:0] given_y;
    logic [POINT_W-1:0] given_z;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd0, 12'd0, 16'd500, CHK_PREDICT, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd1, 12'd0, 16'd1000, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd0, 12'd3, 16'd1000, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd2, 12'd2, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4094, 12'd4094, 16'd5000, CHK_PREDICT,
      24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd100, 12'd100, 16'd499, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd100, 12'd100, 16'd5001, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4095, 12'd4094, 16'd1000, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd640, 12'd480, 16'd1234, CHK_PREDICT, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_SKIP_STEP, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MIN_DEPTH, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MAX_DEPTH, 24'hFFFFFF, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_METRES_PER_UNIT, 24'hFFFFFF, 12'd0, 12'd0, 16'd0, CHK_DROP,
      24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_INV_FOCAL_COL, 24'hFFFFFF, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_INV_FOCAL_ROW, 24'hFFFFFF, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_CENTER_COL, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_CENTER_ROW, 24'hFFFF, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4095, 12'd0, 16'd256, CHK_GIVEN,
      SAT_POS, SAT_NEG, 24'hFFFFFF},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4095, 12'd4095, 16'd257, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd1, 12'd1, 16'd1, CHK_PREDICT, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4095, 12'd4095, 16'hFFFF, CHK_DROP,
      24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MIN_DEPTH, 24'd100, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MAX_DEPTH, 24'd99, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd7, 12'd9, 16'd1, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd0, 12'd0, 16'hFFFF, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_CENTER_ROW, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_INV_FOCAL_COL, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_INV_FOCAL_ROW, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_METRES_PER_UNIT, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MIN_DEPTH, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_MAX_DEPTH, 24'd0, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b1, CFG_SKIP_STEP, 24'd15, 12'd0, 12'd0, 16'd0, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd0, 12'd0, 16'hFFFF, CHK_GIVEN, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd15, 12'd30, 16'd1, CHK_GIVEN, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd14, 12'd15, 16'd7, CHK_DROP, 24'd0, 24'd0, 24'd0},
    '{1'b0, CFG_CENTER_COL, 24'd0, 12'd4095, 12'd4095, 16'hFFFF, CHK_GIVEN,
      24'd0, 24'd0, 24'd0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata  = '0;  // pixel_col, pixel_row, depth_raw
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // point_x, point_y, point_z

  cfg_t   cam_cfg = CFG_RESET;
  point_t expected_points [$];
  int     burst_left     = 0;
  int     pixels_sent    = 0;
  int     pixels_dropped = 0;
  int     points_checked = 0;
  int     mismatches     = 0;
  int     cycle_cnt      = 0;
  bit     hold_req       = 1'b0;

  depth_pixel_backprojection_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [POINT_W-1:0] axis_offset(input logic [CB-1:0] coord,
                                                     input logic [CENTER_W-1:0] center,
                                                     input logic [RECIP_W-1:0] inv_f,
                                                     input logic [63:0] z);
    logic [63:0] scaled, offs, prod, upper, lower, mag;
    logic        neg;
    scaled = {48'd0, coord, 4'd0};
    neg    = scaled < 64'(center);
    offs   = neg ? 64'(center) - scaled : scaled - 64'(center);
    prod   = offs * z;
    upper  = prod * 64'(inv_f[23:12]);
    lower  = prod * 64'(inv_f[11:0]);
    mag    = (upper + (lower >> 12) + 64'd32768) >> 16;
    if (neg) begin
      if (mag > 64'(SAT_NEG)) mag = 64'(SAT_NEG);
      return 24'(64'd0 - mag);
    end
    if (mag > 64'(SAT_POS)) mag = 64'(SAT_POS);
    return mag[23:0];
  endfunction

  function automatic bit backproject(input pixel_t px, output point_t pt);
    logic [63:0]       z;
    logic [STEP_W-1:0] step;
    pt   = '0;
    step = (cam_cfg.skip_step == 0) ? 4'd1 : cam_cfg.skip_step;
    if ((px.pixel_col % step) != 0 || (px.pixel_row % step) != 0) return 1'b0;
    if (px.depth_raw == 0) return 1'b0;
    z = (64'(px.depth_raw) * 64'(cam_cfg.metres_per_unit) + 64'd128) >> 8;
    if (z < 64'(cam_cfg.min_depth) || z > 64'(cam_cfg.max_depth)) return 1'b0;
    pt.x = axis_offset(px.pixel_col, cam_cfg.center_col, cam_cfg.inv_focal_col, z);
    pt.y = axis_offset(px.pixel_row, cam_cfg.center_row, cam_cfg.inv_focal_row, z);
    pt.z = z[23:0];
    return 1'b1;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cfg_field(input cfg_t c, input cfg_reg_e r);
    case (r)
      CFG_CENTER_COL:      return 24'(c.center_col);
      CFG_CENTER_ROW:      return 24'(c.center_row);
      CFG_INV_FOCAL_COL:   return c.inv_focal_col;
      CFG_INV_FOCAL_ROW:   return c.inv_focal_row;
      CFG_METRES_PER_UNIT: return c.metres_per_unit;
      CFG_MIN_DEPTH:       return c.min_depth;
      CFG_MAX_DEPTH:       return c.max_depth;
      default:             return 24'(c.skip_step);
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (r)
      CFG_CENTER_COL:      cam_cfg.center_col      = v[15:0];
      CFG_CENTER_ROW:      cam_cfg.center_row      = v[15:0];
      CFG_INV_FOCAL_COL:   cam_cfg.inv_focal_col   = v;
      CFG_INV_FOCAL_ROW:   cam_cfg.inv_focal_row   = v;
      CFG_METRES_PER_UNIT: cam_cfg.metres_per_unit = v;
      CFG_MIN_DEPTH:       cam_cfg.min_depth       = v;
      CFG_MAX_DEPTH:       cam_cfg.max_depth       = v;
      default:             cam_cfg.skip_step       = v[3:0];
    endcase
  endtask

  // drop valid, wait out every pending point and the pipeline depth
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 3) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      write_reg(cfg_reg_e'(i), cfg_field(c, cfg_reg_e'(i)));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_t px, input bit has_pt, input point_t pt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pixels_sent++;
    if (has_pt) expected_points.insert(expected_points.size(), pt);
    else pixels_dropped++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points pending", $time, expected_points.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected point x=%h y=%h z=%h", $time, got.x, got.y, got.z);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (got.x !== want.x) begin
          mismatches++;
          $display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
        end
        if (got.y !== want.y) begin
          mismatches++;
          $display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
        end
        if (got.z !== want.z) begin
          mismatches++;
          $display("%0t: point_z expected %h actual %h", $time, want.z, got.z);
        end
      end
    end
  end

  initial begin
    int mode, mode_left;
    mode      = 0;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
          2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= ((cycle_cnt % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    pixel_t      px;
    point_t      pt;
    cfg_t        c;
    bit          has_pt, prev_cfg;
    int          kind, sent_in_phase, made_in_phase, step;
    int          ra, rb;
    logic [63:0] raw_lo, raw_hi, zlim, mask;

    prev_cfg = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        if (!prev_cfg) drain_pipeline();
        write_reg(DIR_TAB[i].cfg_sel, DIR_TAB[i].cfg_val);
        prev_cfg = 1'b1;
      end else begin
        cfg_we_i <= 1'b0;
        prev_cfg = 1'b0;
        px = '{depth_raw: DIR_TAB[i].raw, pixel_row: DIR_TAB[i].row,
               pixel_col: DIR_TAB[i].col};
        case (DIR_TAB[i].chk)
          CHK_PREDICT: has_pt = backproject(px, pt);
          CHK_GIVEN: begin
            has_pt = 1'b1;
            pt = '{z: DIR_TAB[i].given_z, y: DIR_TAB[i].given_y, x: DIR_TAB[i].given_x};
          end
          default: has_pt = 1'b0;
        endcase
        send_pixel(px, has_pt, pt);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      c = CFG_RESET;
      if (ph == 1) begin
        c = '{center_col: 16'hFFFF, center_row: 16'h0000, inv_focal_col: 24'hFFFFFF,
              inv_focal_row: 24'hFFFFFF, metres_per_unit: 24'hFFFFFF, min_depth: 24'd0,
              max_depth: 24'hFFFFFF, skip_step: 4'd1};
      end else if (ph > 1) begin
        c.center_col      = 16'($urandom_range(0, 16'hFFFF));
        c.center_row      = 16'($urandom_range(0, 16'hFFFF));
        mask              = (64'd1 << $urandom_range(8, 24)) - 1;
        c.inv_focal_col   = 24'($urandom & mask);
        mask              = (64'd1 << $urandom_range(8, 24)) - 1;
        c.inv_focal_row   = 24'($urandom & mask);
        mask              = (64'd1 << $urandom_range(8, 24)) - 1;
        c.metres_per_unit = 24'(($urandom & mask) | 1);
        ra = $urandom_range(1, 2000);
        rb = $urandom_range(ra, 65535);
        zlim = (64'(ra) * c.metres_per_unit + 128) >> 8;
        c.min_depth = ($urandom_range(0, 3) == 0) ? 24'd0 :
                      (zlim > 64'hFFFFFF) ? 24'hFFFFFF : zlim[23:0];
        zlim = (64'(rb) * c.metres_per_unit + 128) >> 8;
        c.max_depth = (zlim > 64'hFFFFFF) ? 24'hFFFFFF : zlim[23:0];
        c.skip_step = 4'($urandom_range(0, 15));
      end
      apply_cfg(c);

      // raw depth bounds around the accepted range; the full range if they cross
      raw_lo = (64'(c.min_depth) << 8) / 64'(c.metres_per_unit);
      raw_hi = ((64'(c.max_depth) << 8) + 255) / 64'(c.metres_per_unit) + 1;
      if (raw_lo < 1) raw_lo = 1;
      if (raw_hi > 65535) raw_hi = 65535;
      if (raw_lo > raw_hi) begin
        raw_lo = 1;
        raw_hi = 65535;
      end
      step = (c.skip_step == 0) ? 1 : c.skip_step;

      sent_in_phase = 0;
      made_in_phase = 0;
      while (made_in_phase < PHASE_PTS && sent_in_phase < 4 * PHASE_PTS) begin
        if (ph == 0 && sent_in_phase == 30) hold_req = 1'b1;
        kind = $urandom_range(0, 99);
        px.pixel_col = CB'(step * $urandom_range(0, 4095 / step));
        px.pixel_row = CB'(step * $urandom_range(0, 4095 / step));
        px.depth_raw = DEPTH_W'($urandom_range(32'(raw_lo), 32'(raw_hi)));
        if (kind >= 70 && kind < 80) begin
          px.pixel_col = CB'($urandom);
          px.pixel_row = CB'($urandom);
        end else if (kind >= 80 && kind < 88) begin
          px.depth_raw = '0;
        end else if (kind >= 88 && kind < 94) begin
          px.depth_raw = DEPTH_W'($urandom);
        end else if (kind >= 94) begin
          px = pixel_t'($urandom);
          px.depth_raw = DEPTH_W'($urandom);
        end
        has_pt = backproject(px, pt);
        send_pixel(px, has_pt, pt);
        sent_in_phase++;
        if (has_pt) made_in_phase++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (4 * NUM_STAGES) @(posedge clk_i);

    $display("Run covered %0d pixels (%0d dropped) over %0d camera setups,",
             pixels_sent, pixels_dropped, NUM_PHASES);
    $display("checking %0d points incl. saturation, range edges and random skip steps.",
             points_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dpb_pkg.sv
rtl/dpb_cfg_regs.sv
rtl/dpb_axis.sv
rtl/depth_pixel_backprojection_unit.sv
verif/tb_depth_pixel_backprojection_unit.sv
